>>> src/scm_pkg.sv
// Shared types and constants for the scrollback column mapper.
`default_nettype none
package scm_pkg;

   localparam int REQ_TYPE_W   = 3;
   localparam int CHAR_W       = 8;
   localparam int COLOUR_W     = 8;
   localparam int QUERY_COL_W  = 4;
   localparam int GLYPH_COL_W  = 3;
   localparam int TARGET_COL_W = 4;
   localparam int OFFSET_W     = 9;
   localparam int COUNT_W      = 32;
   localparam int ENTRY_W      = CHAR_W + COLOUR_W;

   // Signed column difference, its magnitude and the reciprocal used for the pitch division.
   localparam int LOOKUP_W = 12;
   localparam int MAG_W    = 10;
   localparam int RECIP_W  = 16;
   localparam int PITCH_W  = 4;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH    = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PAST    = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_PRESENT = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SNAP    = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY   = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  req_type;
      logic [CHAR_W-1:0]      char_code;
      logic [COLOUR_W-1:0]    char_colour;
      logic [QUERY_COL_W-1:0] query_col;
   } scm_req_word_type;

   typedef struct packed {
      logic                    visible;
      logic [CHAR_W-1:0]       glyph_char;
      logic [GLYPH_COL_W-1:0]  glyph_column;
      logic [COLOUR_W-1:0]     glyph_colour;
      logic [TARGET_COL_W-1:0] target_col;
      logic                    moved;
      logic [OFFSET_W-1:0]     offset_now;
   } scm_rsp_word_type;

   typedef struct packed {
      logic accept;
      logic calc_diff;
      logic calc_quot;
      logic fetch;
      logic load_rsp;
   } scm_cmd_type;

   typedef struct packed {
      logic lookup;
   } scm_status_type;

endpackage
`default_nettype wire

>>> src/scm_ifs.sv
// Valid/ready channel interfaces for the request and response words.
`default_nettype none
interface scm_req_if import scm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [CHAR_W-1:0]      char_code;
   logic [COLOUR_W-1:0]    char_colour;
   logic [QUERY_COL_W-1:0] query_col;

   modport source (output valid, output req_type, output char_code, output char_colour,
                   output query_col, input ready);
   modport sink (input valid, input req_type, input char_code, input char_colour,
                 input query_col, output ready);
endinterface

interface scm_rsp_if import scm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    visible;
   logic [CHAR_W-1:0]       glyph_char;
   logic [GLYPH_COL_W-1:0]  glyph_column;
   logic [COLOUR_W-1:0]     glyph_colour;
   logic [TARGET_COL_W-1:0] target_col;
   logic                    moved;
   logic [OFFSET_W-1:0]     offset_now;

   modport source (output valid, output visible, output glyph_char, output glyph_column,
                   output glyph_colour, output target_col, output moved, output offset_now,
                   input ready);
   modport sink (input valid, input visible, input glyph_char, input glyph_column,
                 input glyph_colour, input target_col, input moved, input offset_now,
                 output ready);
endinterface
`default_nettype wire

>>> src/scm_dpath.sv
// Datapath: ring memory, count and scroll state, pitch division and the response register.
`default_nettype none
module scm_dpath import scm_pkg::*; #(
   parameter int RING_DEPTH  = 64,
   parameter int MATRIX_COLS = 16,
   parameter int SMALL_WIDTH = 3,
   parameter int LARGE_WIDTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  scm_cmd_type      cmd,
   input  scm_req_word_type req_word,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output scm_status_type   status,
   output scm_rsp_word_type rsp_word
);

   localparam int DW    = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(RING_DEPTH + 1);
   localparam int SUMW  = DW + 1;
   localparam int CMPW  = (MAG_W > CW) ? MAG_W : CW;
   localparam int LIMW  = (CW + PITCH_W > OFFSET_W + 1) ? CW + PITCH_W : OFFSET_W + 1;
   localparam int COLW  = ($clog2(MATRIX_COLS) > QUERY_COL_W) ? $clog2(MATRIX_COLS) : QUERY_COL_W;
   localparam int PRODW = MAG_W + RECIP_W;

   localparam logic [PITCH_W-1:0]  SMALL_GLYPH = PITCH_W'(SMALL_WIDTH);
   localparam logic [PITCH_W-1:0]  LARGE_GLYPH = PITCH_W'(LARGE_WIDTH);
   localparam logic [PITCH_W-1:0]  SMALL_PITCH = PITCH_W'(SMALL_WIDTH + 1);
   localparam logic [PITCH_W-1:0]  LARGE_PITCH = PITCH_W'(LARGE_WIDTH + 1);
   localparam logic [LOOKUP_W-1:0] SMALL_LEAD  = LOOKUP_W'(MATRIX_COLS - 2 * SMALL_WIDTH - 1);
   localparam logic [LOOKUP_W-1:0] LARGE_LEAD  = LOOKUP_W'(MATRIX_COLS - 2 * LARGE_WIDTH - 1);
   localparam logic [RECIP_W-1:0]  SMALL_RECIP = RECIP_W'((1 << RECIP_W) / (SMALL_WIDTH + 1) + 1);
   localparam logic [RECIP_W-1:0]  LARGE_RECIP = RECIP_W'((1 << RECIP_W) / (LARGE_WIDTH + 1) + 1);
   localparam logic [COLW-1:0]     EDGE_COL    = COLW'(MATRIX_COLS - 1);
   localparam logic [COLW:0]       COL_LIMIT   = (COLW + 1)'(MATRIX_COLS);
   localparam logic [COUNT_W-1:0]  COUNT_DEPTH = COUNT_W'(RING_DEPTH);
   localparam logic [CW-1:0]       RING_FULL   = CW'(RING_DEPTH);
   localparam logic [DW-1:0]       LAST_SLOT   = DW'(RING_DEPTH - 1);
   localparam logic [SUMW-1:0]     SUM_DEPTH   = SUMW'(RING_DEPTH);

   logic                    font_ff, font_in;
   logic [OFFSET_W-1:0]     scroll_ff, scroll_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [DW-1:0]           wptr_ff, wptr_in;
   logic [COLW-1:0]         col_ff, col_in;
   logic                    lookup_ff, lookup_in;
   logic                    moved_ff, moved_in;
   logic [TARGET_COL_W-1:0] target_ff, target_in;
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [MAG_W-1:0]        quot_ff, quot_in;
   logic                    hit_ff, hit_in;
   logic [PITCH_W-1:0]      gcol_ff, gcol_in;
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic [ENTRY_W-1:0]      ring_mem_ff [RING_DEPTH];
   scm_rsp_word_type        rsp_ff, rsp_in;

   logic [PITCH_W-1:0]  glyph_w, pitch;
   logic [LOOKUP_W-1:0] lead, diff;
   logic [RECIP_W-1:0]  recip;
   logic [CW-1:0]       in_ring;
   logic [LIMW-1:0]     lim_full;
   logic                can_past, count_nz, query_in_range;
   logic [PRODW-1:0]    prod;
   logic [MAG_W-1:0]    back, rem_full, back_cnt;
   logic [PITCH_W-1:0]  rem;
   logic                rem_nz;
   logic [SUMW-1:0]     slot_sum, slot_wrap;
   logic [DW-1:0]       slot;

   always_comb begin
      glyph_w        = font_ff ? LARGE_GLYPH : SMALL_GLYPH;
      pitch          = font_ff ? LARGE_PITCH : SMALL_PITCH;
      lead           = font_ff ? LARGE_LEAD : SMALL_LEAD;
      recip          = font_ff ? LARGE_RECIP : SMALL_RECIP;
      in_ring        = (count_ff >= COUNT_DEPTH) ? RING_FULL : count_ff[CW-1:0];
      lim_full       = LIMW'(in_ring) * LIMW'(pitch);
      can_past       = (LIMW'(scroll_ff) < lim_full) && (scroll_ff != OFFSET_MAX);
      count_nz       = (count_ff != '0);
      query_in_range = ((COLW + 1)'(req_word.query_col) < COL_LIMIT);
   end

   always_comb begin
      font_in   = font_ff;
      scroll_in = scroll_ff;
      count_in  = count_ff;
      wptr_in   = wptr_ff;
      col_in    = col_ff;
      lookup_in = lookup_ff;
      moved_in  = moved_ff;
      target_in = target_ff;
      if (cmd.accept) begin
         col_in    = '0;
         lookup_in = 1'b0;
         moved_in  = 1'b0;
         target_in = '0;
         case (req_word.req_type)
            REQ_PUSH: begin
               scroll_in = '0;
               count_in  = count_ff + 1'b1;
               wptr_in   = (count_ff == COUNT_MAX || wptr_ff == LAST_SLOT) ? '0 : wptr_ff + 1'b1;
            end
            REQ_PAST: begin
               if (can_past) begin
                  scroll_in = scroll_ff + 1'b1;
                  moved_in  = 1'b1;
                  lookup_in = count_nz;
               end
            end
            REQ_PRESENT: begin
               col_in    = EDGE_COL;
               target_in = EDGE_COL[TARGET_COL_W-1:0];
               if (scroll_ff != '0) begin
                  scroll_in = scroll_ff - 1'b1;
                  moved_in  = 1'b1;
                  lookup_in = count_nz;
               end
            end
            REQ_SNAP: begin
               scroll_in = '0;
               moved_in  = (scroll_ff != '0);
            end
            REQ_QUERY: begin
               col_in    = COLW'(req_word.query_col);
               target_in = req_word.query_col;
               lookup_in = count_nz && query_in_range;
            end
            default: begin
            end
         endcase
      end
      if (csr_wr_en) begin
         font_in   = csr_wr_data;
         scroll_in = '0;
      end
   end

   // Column position relative to the newest glyph, then floor division by the pitch.
   always_comb begin
      diff   = LOOKUP_W'(col_ff) - lead - LOOKUP_W'(scroll_ff);
      neg_in = diff[LOOKUP_W-1];
      mag_in = neg_in ? MAG_W'(-diff) : MAG_W'(diff);

      prod    = PRODW'(mag_ff) * PRODW'(recip);
      quot_in = prod[PRODW-1 -: MAG_W];

      back     = MAG_W'(quot_ff * MAG_W'(pitch));
      rem_full = mag_ff - back;
      rem      = rem_full[PITCH_W-1:0];
      rem_nz   = (rem != '0);
      gcol_in  = (neg_ff && rem_nz) ? pitch - rem : rem;
      back_cnt = neg_ff ? quot_ff + MAG_W'(rem_nz) : '0;
      hit_in   = lookup_ff && (neg_ff || quot_ff == '0) &&
                 (CMPW'(back_cnt) < CMPW'(in_ring)) && (gcol_in < glyph_w);

      slot_sum  = SUMW'(wptr_ff) + SUM_DEPTH - 1'b1 - SUMW'(back_cnt);
      slot_wrap = (slot_sum >= SUM_DEPTH) ? slot_sum - SUM_DEPTH : slot_sum;
      slot      = slot_wrap[DW-1:0];
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.visible      = lookup_ff && hit_ff;
      rsp_in.glyph_char   = rsp_in.visible ? rd_data_ff[ENTRY_W-1 -: CHAR_W] : '0;
      rsp_in.glyph_colour = rsp_in.visible ? rd_data_ff[COLOUR_W-1:0] : '0;
      rsp_in.glyph_column = rsp_in.visible ? gcol_ff[GLYPH_COL_W-1:0] : '0;
      rsp_in.target_col   = target_ff;
      rsp_in.moved        = moved_ff;
      rsp_in.offset_now   = scroll_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_ff   <= 1'b0;
         scroll_ff <= '0;
         count_ff  <= '0;
         wptr_ff   <= '0;
         lookup_ff <= 1'b0;
      end else begin
         font_ff   <= font_in;
         scroll_ff <= scroll_in;
         count_ff  <= count_in;
         wptr_ff   <= wptr_in;
         lookup_ff <= lookup_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      moved_ff  <= moved_in;
      target_ff <= target_in;
      if (cmd.calc_diff) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (cmd.calc_quot) begin
         quot_ff <= quot_in;
      end
      if (cmd.fetch) begin
         hit_ff  <= hit_in;
         gcol_ff <= gcol_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_word.req_type == REQ_PUSH) begin
         ring_mem_ff[wptr_ff] <= {req_word.char_code, req_word.char_colour};
      end
      if (cmd.fetch) begin
         rd_data_ff <= ring_mem_ff[slot];
      end
   end

   assign status.lookup = lookup_ff;
   assign rsp_word      = rsp_ff;

   a_scroll_in_limit: assert property (@(posedge clock) disable iff (reset)
      LIMW'(scroll_ff) <= lim_full)
      else $error("scroll offset is past the history limit");

endmodule
`default_nettype wire

>>> src/scm_ctrl.sv
// Controller: sequences each word through the datapath and owns the response valid.
`default_nettype none
module scm_ctrl import scm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  scm_status_type status,
   output scm_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARITH,
      ST_DIVIDE,
      ST_REMAIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.calc_diff = (state_ff == ST_ARITH);
      cmd.calc_quot = (state_ff == ST_DIVIDE);
      cmd.fetch     = (state_ff == ST_REMAIN);
      cmd.load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_ARITH;
               end
            end
            ST_ARITH: begin
               state_ff <= status.lookup ? ST_DIVIDE : ST_DONE;
            end
            ST_DIVIDE: begin
               state_ff <= ST_REMAIN;
            end
            ST_REMAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (cmd.load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ARITH))
      else $error("accepted word did not start the arithmetic step");

   a_divide_then_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |=> (state_ff == ST_REMAIN))
      else $error("division step not followed by the remainder step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response load did not present a word and return to idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && state_ff == ST_DONE) |=> (state_ff == ST_DONE))
      else $error("pending response word was overwritten");

endmodule
`default_nettype wire

>>> src/scrollback_column_mapper.sv
// Top level of the scrollback column mapper: channels, register port and the two units.
//
// The request channel carries one word per command: push a character with its colour,
// step the view one column into the past or toward the present, snap to the present,
// or query a matrix column. Every request word yields exactly one response word on the
// response channel, in order, reporting the looked-up glyph column, whether the view
// moved, and the scroll offset afterward. The csr port writes the font size select;
// any write also returns the view to the present.
// A query of a matrix column once history is not empty, or a step that moves, walks the
// controller through the shared subtract, reciprocal multiply, remainder and ring read
// steps before the response register is loaded and the response made valid; other
// commands take only the subtract step before that load.
// Reset empties the history count, zeros the scroll offset and selects the small font;
// the ring contents are not cleared. A stalled response is held in the output register
// while the next request is still accepted; that request waits for the register.
`default_nettype none
module scrollback_column_mapper import scm_pkg::*; #(
   parameter int RING_DEPTH  = 64,
   parameter int MATRIX_COLS = 16,
   parameter int SMALL_WIDTH = 3,
   parameter int LARGE_WIDTH = 5
) (
   input  logic       clock,
   input  logic       reset,
   scm_req_if.sink    req_ch,
   scm_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   scm_cmd_type      cmd;
   scm_status_type   status;
   scm_req_word_type req_word;
   scm_rsp_word_type rsp_word;

   assign req_word.req_type    = req_ch.req_type;
   assign req_word.char_code   = req_ch.char_code;
   assign req_word.char_colour = req_ch.char_colour;
   assign req_word.query_col   = req_ch.query_col;

   scm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scm_dpath #(
      .RING_DEPTH  (RING_DEPTH),
      .MATRIX_COLS (MATRIX_COLS),
      .SMALL_WIDTH (SMALL_WIDTH),
      .LARGE_WIDTH (LARGE_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_word    (rsp_word)
   );

   assign rsp_ch.visible      = rsp_word.visible;
   assign rsp_ch.glyph_char   = rsp_word.glyph_char;
   assign rsp_ch.glyph_column = rsp_word.glyph_column;
   assign rsp_ch.glyph_colour = rsp_word.glyph_colour;
   assign rsp_ch.target_col   = rsp_word.target_col;
   assign rsp_ch.moved        = rsp_word.moved;
   assign rsp_ch.offset_now   = rsp_word.offset_now;

endmodule
`default_nettype wire
